FILE: hw/rtl/drop_oldest_ingest_queue_defines.svh
// Assertion macros shared by the checker files of the drop-oldest ingest queue.
// Both macros expect a signal named clk, and DROPQ_ASSERT one named rst_n, in the scope where used.
`ifndef DROP_OLDEST_INGEST_QUEUE_DEFINES_SVH
`define DROP_OLDEST_INGEST_QUEUE_DEFINES_SVH

// Property checked only while out of reset
`define DROPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define DROPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/dropq_pkg.sv
// Package for the drop-oldest ingest queue: sizes, types, request codes, helpers.
// No dependencies; every other file of the block but the defines header refers to it by scoped names.
`timescale 1ns / 1ps

package dropq_pkg;

  // Sizes
  localparam int RING_SLOTS     = 1024;
  localparam int DROP_LOG_DEPTH = 16;
  localparam int PAYLOAD_BITS   = 64;
  localparam int BUDGET_CAP     = 64;

  localparam int QIDX_W     = $clog2(RING_SLOTS);
  localparam int OCC_W      = QIDX_W + 1;
  localparam int LOG_IDX_W  = (DROP_LOG_DEPTH > 1) ? $clog2(DROP_LOG_DEPTH) : 1;
  localparam int LOG_CNT_W  = $clog2(DROP_LOG_DEPTH + 1);
  localparam int WORD_W     = 64;
  localparam int AMOUNT_W   = 11;
  localparam int MAXC_W     = 5;
  localparam int BUDGET_W   = 7;
  localparam int SHED_W     = 32;
  // Smallest depth with depth*4 >= RING_SLOTS*3
  localparam int NEAR_FULL_LEVEL = (RING_SLOTS * 3 + 3) / 4;

  typedef logic [QIDX_W-1:0]       qidx_t;
  typedef logic [OCC_W-1:0]        occ_t;
  typedef logic [LOG_IDX_W-1:0]    log_idx_t;
  typedef logic [LOG_CNT_W-1:0]    log_cnt_t;
  typedef logic [WORD_W-1:0]       word_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;
  typedef logic [AMOUNT_W-1:0]     amount_t;
  typedef logic [MAXC_W-1:0]       maxc_t;
  typedef logic [BUDGET_W-1:0]     budget_t;
  typedef logic [SHED_W-1:0]       shed_t;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_DRAIN   = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_TAKE    = 2'd3
  } kind_t;

  // One ring entry
  typedef struct packed {
    payload_t payload;
    word_t    seq;
  } entry_t;

  // One result
  typedef struct packed {
    kind_t   kind_echo;
    word_t   payload_out;
    word_t   seq_out;
    logic    accepted;
    logic    has_entry;
    amount_t amount;
    logic    nearly_full;
    shed_t   dropped_total;
    logic    last;
  } result_t;

  function automatic logic near_full(occ_t occ);
    return occ >= occ_t'(NEAR_FULL_LEVEL);
  endfunction

endpackage

FILE: hw/rtl/dropq_in_if.sv
// Request channel of the drop-oldest ingest queue: valid/ready plus request fields.
// Depends on dropq_pkg.
`timescale 1ns / 1ps

interface dropq_in_if;
  logic                  valid;
  logic                  ready;
  dropq_pkg::kind_t      kind;
  dropq_pkg::word_t      payload;
  dropq_pkg::word_t      seq;
  dropq_pkg::maxc_t      max_count;

  modport source (output valid, kind, payload, seq, max_count, input ready);
  modport sink   (input valid, kind, payload, seq, max_count, output ready);
  modport monitor(input valid, ready, kind, payload, seq, max_count);
endinterface

FILE: hw/rtl/dropq_out_if.sv
// Result channel of the drop-oldest ingest queue: valid/ready plus result fields.
// Depends on dropq_pkg.
`timescale 1ns / 1ps

interface dropq_out_if;
  logic                 valid;
  logic                 ready;
  dropq_pkg::kind_t     kind_echo;
  dropq_pkg::word_t     payload_out;
  dropq_pkg::word_t     seq_out;
  logic                 accepted;
  logic                 has_entry;
  dropq_pkg::amount_t   amount;
  logic                 nearly_full;
  dropq_pkg::shed_t     dropped_total;
  logic                 last;

  modport source (output valid, kind_echo, payload_out, seq_out, accepted, has_entry,
                  amount, nearly_full, dropped_total, last, input ready);
  modport sink   (input valid, kind_echo, payload_out, seq_out, accepted, has_entry,
                  amount, nearly_full, dropped_total, last, output ready);
  modport monitor(input valid, ready, kind_echo, payload_out, seq_out, accepted,
                  has_entry, amount, nearly_full, dropped_total, last);
endinterface

FILE: hw/rtl/drop_oldest_ingest_queue.sv
// Drop-oldest ingest queue: ring queue in one RAM, shed log, drain/discard/take requests.
// Requests are handled one at a time. Push and discard: the request moves to ST_PUSH / ST_ONE,
// which loads the result into the output register. Drain and take-log: results follow one per
// cycle while the output register is free, paced by the single RAM read port / log read.
// Reset (rst_n low, synchronous) clears indices, depth, log count, shed count, budget (64)
// and the output register; the RAM and log contents are not cleared.
`timescale 1ns / 1ps

module drop_oldest_ingest_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  dropq_in_if.sink             in_if,
  dropq_out_if.source          out_if,
  input  logic                 cfg_we,
  input  dropq_pkg::budget_t   cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PUSH  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_TAKE  = 5'b01000,
    ST_ONE   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  dropq_pkg::kind_t      req_kind_r, req_kind_nxt;
  dropq_pkg::payload_t   req_payload_r, req_payload_nxt;
  dropq_pkg::word_t      req_seq_r, req_seq_nxt;
  dropq_pkg::amount_t    amt_r, amt_nxt;
  dropq_pkg::budget_t    drain_cnt_r, drain_cnt_nxt;
  dropq_pkg::log_cnt_t   take_n_r, take_n_nxt;
  dropq_pkg::log_cnt_t   take_i_r, take_i_nxt;
  dropq_pkg::qidx_t      rd_idx_r, rd_idx_nxt;
  dropq_pkg::qidx_t      wr_idx_r, wr_idx_nxt;
  dropq_pkg::occ_t       occ_r, occ_nxt;
  dropq_pkg::log_cnt_t   log_cnt_r, log_cnt_nxt;
  dropq_pkg::shed_t      shed_r, shed_nxt;
  dropq_pkg::budget_t    budget_r, budget_nxt;
  logic                  out_valid_r, out_valid_nxt;
  dropq_pkg::result_t    out_r;
  dropq_pkg::word_t      log_rd_r;

  dropq_pkg::word_t      log_mem [dropq_pkg::DROP_LOG_DEPTH];

  logic                  mem_rd_en;
  logic                  mem_wr_en;
  dropq_pkg::entry_t     mem_wr_data;
  dropq_pkg::entry_t     mem_rd_data;
  logic                  log_we;
  logic                  log_rd_en;
  dropq_pkg::log_idx_t   log_rd_idx;
  logic                  emit;
  dropq_pkg::result_t    res;
  logic                  out_free;
  logic                  full;
  dropq_pkg::occ_t       push_occ;
  dropq_pkg::budget_t    budget_eff;
  logic                  drain_last;
  logic                  take_last;
  dropq_pkg::log_cnt_t   take_n;

  // Ring RAM; a push reads the oldest slot in ST_IDLE and writes it in ST_PUSH, so no
  // read and write of the same slot ever fall in one cycle
  assign mem_wr_data.payload = req_payload_r;
  assign mem_wr_data.seq     = req_seq_r;

  dropq_ring_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_idx_r),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (mem_rd_data)
  );

  // Handshake
  assign in_if.ready = (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_if.ready;

  // Derived values
  assign full       = (occ_r == dropq_pkg::occ_t'(dropq_pkg::RING_SLOTS));
  assign push_occ   = full ? occ_r : occ_r + dropq_pkg::occ_t'(1);
  assign budget_eff = (budget_r == '0 ||
                       budget_r > dropq_pkg::budget_t'(dropq_pkg::BUDGET_CAP)) ?
                      dropq_pkg::budget_t'(dropq_pkg::BUDGET_CAP) : budget_r;
  assign drain_last = (drain_cnt_r == budget_eff) || (occ_r == '0);
  assign take_last  = (dropq_pkg::log_cnt_t'(take_i_r + 1'b1) == take_n_r);
  assign take_n     = (32'(log_cnt_r) <= 32'(in_if.max_count)) ?
                      log_cnt_r : dropq_pkg::log_cnt_t'(in_if.max_count);

  // Request sequencer
  always_comb begin
    state_nxt       = state_r;
    req_kind_nxt    = req_kind_r;
    req_payload_nxt = req_payload_r;
    req_seq_nxt     = req_seq_r;
    amt_nxt         = amt_r;
    drain_cnt_nxt   = drain_cnt_r;
    take_n_nxt      = take_n_r;
    take_i_nxt      = take_i_r;
    rd_idx_nxt      = rd_idx_r;
    wr_idx_nxt      = wr_idx_r;
    occ_nxt         = occ_r;
    log_cnt_nxt     = log_cnt_r;
    shed_nxt        = shed_r;
    mem_rd_en       = 1'b0;
    mem_wr_en       = 1'b0;
    log_we          = 1'b0;
    log_rd_en       = 1'b0;
    log_rd_idx      = '0;
    emit            = 1'b0;
    res             = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          req_kind_nxt    = in_if.kind;
          req_payload_nxt = dropq_pkg::payload_t'(in_if.payload);
          req_seq_nxt     = in_if.seq;
          case (in_if.kind)
            dropq_pkg::KIND_PUSH: begin
              // fetch the oldest entry in case it gets shed
              mem_rd_en = 1'b1;
              state_nxt = ST_PUSH;
            end
            dropq_pkg::KIND_DRAIN: begin
              if (occ_r == '0) begin
                amt_nxt   = '0;
                state_nxt = ST_ONE;
              end else begin
                mem_rd_en     = 1'b1;
                rd_idx_nxt    = rd_idx_r + dropq_pkg::qidx_t'(1);
                occ_nxt       = occ_r - dropq_pkg::occ_t'(1);
                drain_cnt_nxt = dropq_pkg::budget_t'(1);
                state_nxt     = ST_DRAIN;
              end
            end
            dropq_pkg::KIND_DISCARD: begin
              amt_nxt    = dropq_pkg::amount_t'(occ_r);
              rd_idx_nxt = wr_idx_r;
              occ_nxt    = '0;
              state_nxt  = ST_ONE;
            end
            default: begin
              // take drop log: whole log is cleared regardless of count
              log_cnt_nxt = '0;
              take_n_nxt  = take_n;
              take_i_nxt  = '0;
              if (take_n == '0) begin
                amt_nxt   = dropq_pkg::amount_t'(occ_r);
                state_nxt = ST_ONE;
              end else begin
                // fetch the oldest logged sequence
                log_rd_en = 1'b1;
                state_nxt = ST_TAKE;
              end
            end
          endcase
        end
      end

      ST_PUSH: begin
        if (out_free) begin
          emit      = 1'b1;
          mem_wr_en = 1'b1;
          wr_idx_nxt = wr_idx_r + dropq_pkg::qidx_t'(1);
          occ_nxt   = push_occ;
          if (full) begin
            rd_idx_nxt = rd_idx_r + dropq_pkg::qidx_t'(1);
            shed_nxt   = shed_r + dropq_pkg::shed_t'(1);
            if (log_cnt_r != dropq_pkg::log_cnt_t'(dropq_pkg::DROP_LOG_DEPTH)) begin
              log_we      = 1'b1;
              log_cnt_nxt = log_cnt_r + dropq_pkg::log_cnt_t'(1);
            end
          end
          res.kind_echo     = dropq_pkg::KIND_PUSH;
          res.accepted      = !full;
          res.amount        = dropq_pkg::amount_t'(push_occ);
          res.nearly_full   = dropq_pkg::near_full(push_occ);
          res.dropped_total = shed_nxt;
          res.last          = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end

      ST_DRAIN: begin
        // one entry out per cycle while the output register is free; next read issued as this one leaves
        if (out_free) begin
          emit              = 1'b1;
          res.kind_echo     = dropq_pkg::KIND_DRAIN;
          res.payload_out   = dropq_pkg::word_t'(mem_rd_data.payload);
          res.seq_out       = mem_rd_data.seq;
          res.has_entry     = 1'b1;
          res.amount        = dropq_pkg::amount_t'(occ_r);
          res.nearly_full   = dropq_pkg::near_full(occ_r);
          res.dropped_total = shed_r;
          res.last          = drain_last;
          if (drain_last) begin
            state_nxt = ST_IDLE;
          end else begin
            mem_rd_en     = 1'b1;
            rd_idx_nxt    = rd_idx_r + dropq_pkg::qidx_t'(1);
            occ_nxt       = occ_r - dropq_pkg::occ_t'(1);
            drain_cnt_nxt = drain_cnt_r + dropq_pkg::budget_t'(1);
          end
        end
      end

      ST_TAKE: begin
        // one logged sequence out per cycle while the output register is free; next log read issued as this one leaves
        if (out_free) begin
          emit              = 1'b1;
          res.kind_echo     = dropq_pkg::KIND_TAKE;
          res.seq_out       = log_rd_r;
          res.has_entry     = 1'b1;
          res.amount        = dropq_pkg::amount_t'(occ_r);
          res.nearly_full   = dropq_pkg::near_full(occ_r);
          res.dropped_total = shed_r;
          res.last          = take_last;
          if (take_last) begin
            state_nxt = ST_IDLE;
          end else begin
            log_rd_en  = 1'b1;
            log_rd_idx = dropq_pkg::log_idx_t'(take_i_r + dropq_pkg::log_cnt_t'(1));
            take_i_nxt = take_i_r + dropq_pkg::log_cnt_t'(1);
          end
        end
      end

      ST_ONE: begin
        // single result without an entry: discard, empty drain, empty take
        if (out_free) begin
          emit              = 1'b1;
          res.kind_echo     = req_kind_r;
          res.amount        = amt_r;
          res.nearly_full   = dropq_pkg::near_full(occ_r);
          res.dropped_total = shed_r;
          res.last          = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Configuration
  assign budget_nxt = cfg_we ? cfg_wdata : budget_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      occ_r       <= '0;
      log_cnt_r   <= '0;
      shed_r      <= '0;
      budget_r    <= dropq_pkg::budget_t'(dropq_pkg::BUDGET_CAP);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      occ_r       <= occ_nxt;
      log_cnt_r   <= log_cnt_nxt;
      shed_r      <= shed_nxt;
      budget_r    <= budget_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    req_kind_r    <= req_kind_nxt;
    req_payload_r <= req_payload_nxt;
    req_seq_r     <= req_seq_nxt;
    amt_r         <= amt_nxt;
    drain_cnt_r   <= drain_cnt_nxt;
    take_n_r      <= take_n_nxt;
    take_i_r      <= take_i_nxt;
    if (emit) begin
      out_r <= res;
    end
  end

  // Drop log: shed sequence comes from the RAM read issued at the push transfer
  always_ff @(posedge clk) begin
    if (log_we) begin
      log_mem[log_cnt_r[dropq_pkg::LOG_IDX_W-1:0]] <= mem_rd_data.seq;
    end
  end

  // Drop log read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (log_rd_en) begin
      log_rd_r <= log_mem[log_rd_idx];
    end
  end

  // Result channel
  assign out_if.valid         = out_valid_r;
  assign out_if.kind_echo     = out_r.kind_echo;
  assign out_if.payload_out   = out_r.payload_out;
  assign out_if.seq_out       = out_r.seq_out;
  assign out_if.accepted      = out_r.accepted;
  assign out_if.has_entry     = out_r.has_entry;
  assign out_if.amount        = out_r.amount;
  assign out_if.nearly_full   = out_r.nearly_full;
  assign out_if.dropped_total = out_r.dropped_total;
  assign out_if.last          = out_r.last;

endmodule

FILE: hw/rtl/dropq_ring_mem.sv
// Ring storage of the drop-oldest ingest queue: one write port, one read port,
// read data registered. Depends on dropq_pkg.
`timescale 1ns / 1ps

module dropq_ring_mem (
  input  logic              clk,
  input  logic              wr_en,
  input  dropq_pkg::qidx_t  wr_addr,
  input  dropq_pkg::entry_t wr_data,
  input  logic              rd_en,
  input  dropq_pkg::qidx_t  rd_addr,
  output dropq_pkg::entry_t rd_data
);

  dropq_pkg::entry_t mem [dropq_pkg::RING_SLOTS];
  dropq_pkg::entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/dropq_checker.sv
// Port-level checker for the drop-oldest ingest queue, bound to the top level.
// Depends on dropq_pkg and drop_oldest_ingest_queue_defines.svh.
`timescale 1ns / 1ps
`include "drop_oldest_ingest_queue_defines.svh"

module dropq_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input dropq_pkg::kind_t out_kind,
  input logic             out_has_entry,
  input logic             out_last
);

  logic push_result;

  assign push_result = out_valid && (out_kind == dropq_pkg::KIND_PUSH);

  // A waiting result stays until its transfer
  `DROPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // Reset empties the result register
  `DROPQ_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // One request at a time: intake closes after a transfer
  `DROPQ_ASSERT(a_one_request, in_valid && in_ready |=> !in_ready, "request taken while busy")

  // A push answers with one result and no entry
  `DROPQ_ASSERT(a_push_single, push_result |-> out_last && !out_has_entry, "bad push result")

endmodule

bind drop_oldest_ingest_queue dropq_checker u_dropq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_kind      (out_if.kind_echo),
  .out_has_entry (out_if.has_entry),
  .out_last      (out_if.last)
);
